// ----- design/lbb_pkg.sv -----
//------------------------------------------------------------------------------
// lbb_pkg
// Shared widths and pipeline layout of the look-at basis builder.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbb_pkg;

	// Default input coordinate width.
	localparam int COORD_BITS_DEF = 16;

	// Coordinate width after the range fit.
	localparam int C_W      = 16;
	// Width of one row component on the output, Q1.14.
	localparam int ROW_W    = 16;
	// Signed width of the h x d cross product.
	localparam int CR_W     = 33;
	// Signed width of w = d x (h x d), and of its magnitude.
	localparam int W_W      = 49;
	localparam int WM_W     = 48;
	// Half of the magnitude for split squaring.
	localparam int HALF_W   = 24;
	// Width of squared direction terms and their sum.
	localparam int DSQ_W    = 32;
	// Width of squared w terms and their sum.
	localparam int WSQ_W    = 96;
	// Width of the quotient built by the normalization stages.
	localparam int F_W      = 16;
	// Width of one cross product term of two rows.
	localparam int RP_W     = 32;

	// Q1.14 unit and the rounding half for Q2.28 to Q1.14.
	localparam int Q_ONE    = 16384;
	localparam int Q_HALF   = 8192;
	localparam int Q_FRAC   = 14;

	// Pipeline layout.
	localparam int FRONT_STAGES = 6;
	localparam int ITER_STAGES  = F_W;
	localparam int BACK_STAGES  = 2;
	localparam int NUM_STAGES   = FRONT_STAGES + ITER_STAGES + BACK_STAGES;

	// Output transaction layout.
	localparam int OUT_TDATA_W  = 9 * ROW_W;

endpackage

`default_nettype wire

// ----- design/lbb_pipe_ctrl.sv -----
//------------------------------------------------------------------------------
// lbb_pipe_ctrl
// Valid bits and per-stage load enables of the pipeline; empty stages
// are filled even while the output holds a waiting transaction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbb_pipe_ctrl #(
	parameter int NUM_STAGES = lbb_pkg::NUM_STAGES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [NUM_STAGES-1:0]      en
);

	logic [NUM_STAGES-1:0] vld_q;

	// A stage may load when it or any stage after it is empty, or the output drains.
	always_comb begin
		for (int i = 0; i < NUM_STAGES; i++) begin
			en[i] = out_ready || (|((~vld_q) & ({NUM_STAGES{1'b1}} << i)));
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NUM_STAGES-1];

	// Valid bits follow their data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NUM_STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= (i == 0) ? in_valid : vld_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/lbb_front.sv -----
//------------------------------------------------------------------------------
// lbb_front
// Range fit, cross products, squared lengths and the degenerate test.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbb_front #(
	parameter int COORD_BITS = lbb_pkg::COORD_BITS_DEF
) (
	input  wire logic                                     clk,
	input  wire logic [lbb_pkg::FRONT_STAGES-1:0]         en,
	input  wire logic [6*COORD_BITS-1:0]                  coords,
	output logic [2:0][lbb_pkg::DSQ_W-1:0]                dsq,
	output logic [lbb_pkg::DSQ_W-1:0]                     nd,
	output logic [2:0]                                    d_neg,
	output logic [2:0][lbb_pkg::WSQ_W-1:0]                wsq,
	output logic [lbb_pkg::WSQ_W-1:0]                     nw,
	output logic [2:0]                                    w_neg,
	output logic                                          degen
);

	localparam int XW   = (COORD_BITS > lbb_pkg::C_W) ? COORD_BITS : lbb_pkg::C_W;
	localparam int SMAX = XW - lbb_pkg::C_W;
	localparam int SW   = $clog2(SMAX + 2);
	localparam int CW   = lbb_pkg::C_W;
	localparam int HW   = lbb_pkg::HALF_W;

	// Stage 1: shift each vector just far enough to fit 16 signed bits.
	logic signed [XW-1:0] ext [2][3];
	logic signed [XW-1:0] tst;
	logic signed [XW-1:0] shf;
	logic [SW-1:0]        sel [2];
	logic                 all_ok;
	logic signed [CW-1:0] fit [2][3];
	logic signed [CW-1:0] d_s1 [3];
	logic signed [CW-1:0] h_s1 [3];

	always_comb begin
		for (int v = 0; v < 2; v++) begin
			for (int k = 0; k < 3; k++) begin
				ext[v][k] = XW'(signed'(coords[(3*v+k)*COORD_BITS +: COORD_BITS]));
			end
		end
		tst    = '0;
		shf    = '0;
		all_ok = 1'b0;
		for (int v = 0; v < 2; v++) begin
			sel[v] = SW'(SMAX);
			for (int s = SMAX; s >= 0; s--) begin
				all_ok = 1'b1;
				for (int k = 0; k < 3; k++) begin
					tst = ext[v][k] >>> (CW - 1 + s);
					if (!((tst == '0) || (tst == '1))) begin
						all_ok = 1'b0;
					end
				end
				if (all_ok) begin
					sel[v] = SW'(s);
				end
			end
			for (int k = 0; k < 3; k++) begin
				shf       = ext[v][k] >>> sel[v];
				fit[v][k] = shf[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= fit[0][k];
				h_s1[k] <= fit[1][k];
			end
		end
	end

	// Stage 2: c = h x d and the squared direction components.
	logic signed [2*CW-1:0]            pc_a [3];
	logic signed [2*CW-1:0]            pc_b [3];
	logic signed [2*CW-1:0]            sq_d [3];
	logic signed [lbb_pkg::CR_W-1:0]   c_s2 [3];
	logic [lbb_pkg::DSQ_W-1:0]         dsq_s2 [3];
	logic signed [CW-1:0]              d_s2 [3];

	always_comb begin
		pc_a[0] = h_s1[1] * d_s1[2];
		pc_b[0] = h_s1[2] * d_s1[1];
		pc_a[1] = h_s1[2] * d_s1[0];
		pc_b[1] = h_s1[0] * d_s1[2];
		pc_a[2] = h_s1[0] * d_s1[1];
		pc_b[2] = h_s1[1] * d_s1[0];
		for (int k = 0; k < 3; k++) begin
			sq_d[k] = d_s1[k] * d_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < 3; k++) begin
				c_s2[k]   <= lbb_pkg::CR_W'(pc_a[k]) - lbb_pkg::CR_W'(pc_b[k]);
				dsq_s2[k] <= unsigned'(sq_d[k]);
				d_s2[k]   <= d_s1[k];
			end
		end
	end

	// Stage 3: w = d x c, the squared direction length and the degenerate test.
	logic signed [lbb_pkg::W_W-1:0] pw_a [3];
	logic signed [lbb_pkg::W_W-1:0] pw_b [3];
	logic signed [lbb_pkg::W_W-1:0] w_s3 [3];
	logic [lbb_pkg::DSQ_W-1:0]      dsq_s3 [3];
	logic [lbb_pkg::DSQ_W-1:0]      nd_s3;
	logic [2:0]                     dneg_s3;
	logic                           degen_s3;

	always_comb begin
		pw_a[0] = d_s2[1] * c_s2[2];
		pw_b[0] = d_s2[2] * c_s2[1];
		pw_a[1] = d_s2[2] * c_s2[0];
		pw_b[1] = d_s2[0] * c_s2[2];
		pw_a[2] = d_s2[0] * c_s2[1];
		pw_b[2] = d_s2[1] * c_s2[0];
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < 3; k++) begin
				w_s3[k]    <= pw_a[k] - pw_b[k];
				dsq_s3[k]  <= dsq_s2[k];
				dneg_s3[k] <= d_s2[k][CW-1];
			end
			nd_s3    <= dsq_s2[0] + dsq_s2[1] + dsq_s2[2];
			degen_s3 <= ((d_s2[0] == '0) && (d_s2[1] == '0) && (d_s2[2] == '0)) ||
				((c_s2[0] == '0) && (c_s2[1] == '0) && (c_s2[2] == '0));
		end
	end

	// Stage 4: partial products of each squared w magnitude.
	logic [lbb_pkg::W_W-1:0]   w_negv [3];
	logic [lbb_pkg::WM_W-1:0]  w_mag [3];
	logic [2*HW-1:0]           hh_s4 [3];
	logic [2*HW-1:0]           hl_s4 [3];
	logic [2*HW-1:0]           ll_s4 [3];
	logic [2:0]                wneg_s4;
	logic [lbb_pkg::DSQ_W-1:0] dsq_s4 [3];
	logic [lbb_pkg::DSQ_W-1:0] nd_s4;
	logic [2:0]                dneg_s4;
	logic                      degen_s4;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			w_negv[k] = -w_s3[k];
			w_mag[k]  = w_s3[k][lbb_pkg::W_W-1] ? w_negv[k][lbb_pkg::WM_W-1:0] :
				w_s3[k][lbb_pkg::WM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int k = 0; k < 3; k++) begin
				hh_s4[k]   <= w_mag[k][2*HW-1:HW] * w_mag[k][2*HW-1:HW];
				hl_s4[k]   <= w_mag[k][2*HW-1:HW] * w_mag[k][HW-1:0];
				ll_s4[k]   <= w_mag[k][HW-1:0] * w_mag[k][HW-1:0];
				wneg_s4[k] <= w_s3[k][lbb_pkg::W_W-1];
				dsq_s4[k]  <= dsq_s3[k];
			end
			nd_s4    <= nd_s3;
			dneg_s4  <= dneg_s3;
			degen_s4 <= degen_s3;
		end
	end

	// Stage 5: assemble the squared w components.
	logic [lbb_pkg::WSQ_W-1:0] wsq_s5 [3];
	logic [2:0]                wneg_s5;
	logic [lbb_pkg::DSQ_W-1:0] dsq_s5 [3];
	logic [lbb_pkg::DSQ_W-1:0] nd_s5;
	logic [2:0]                dneg_s5;
	logic                      degen_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int k = 0; k < 3; k++) begin
				wsq_s5[k] <= (lbb_pkg::WSQ_W'(hh_s4[k]) << (2 * HW)) +
					(lbb_pkg::WSQ_W'(hl_s4[k]) << (HW + 1)) + lbb_pkg::WSQ_W'(ll_s4[k]);
				dsq_s5[k] <= dsq_s4[k];
			end
			wneg_s5  <= wneg_s4;
			nd_s5    <= nd_s4;
			dneg_s5  <= dneg_s4;
			degen_s5 <= degen_s4;
		end
	end

	// Stage 6: squared length of w.
	logic [lbb_pkg::WSQ_W-1:0] wsq_s6 [3];
	logic [lbb_pkg::WSQ_W-1:0] nw_s6;
	logic [2:0]                wneg_s6;
	logic [lbb_pkg::DSQ_W-1:0] dsq_s6 [3];
	logic [lbb_pkg::DSQ_W-1:0] nd_s6;
	logic [2:0]                dneg_s6;
	logic                      degen_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int k = 0; k < 3; k++) begin
				wsq_s6[k] <= wsq_s5[k];
				dsq_s6[k] <= dsq_s5[k];
			end
			nw_s6    <= wsq_s5[0] + wsq_s5[1] + wsq_s5[2];
			wneg_s6  <= wneg_s5;
			nd_s6    <= nd_s5;
			dneg_s6  <= dneg_s5;
			degen_s6 <= degen_s5;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dsq[k] = dsq_s6[k];
			wsq[k] = wsq_s6[k];
		end
	end

	assign nd    = nd_s6;
	assign d_neg = dneg_s6;
	assign nw    = nw_s6;
	assign w_neg = wneg_s6;
	assign degen = degen_s6;

endmodule

`default_nettype wire

// ----- design/lbb_norm_lane.sv -----
//------------------------------------------------------------------------------
// lbb_norm_lane
// One component of a unit row: round(a * 2^14 / sqrt(n2)) found one
// quotient bit per stage with an exact remainder, no multipliers.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbb_norm_lane #(
	parameter int N2_W = lbb_pkg::DSQ_W
) (
	input  wire logic                               clk,
	input  wire logic [lbb_pkg::ITER_STAGES-1:0]    en,
	input  wire logic                               neg_in,
	input  wire logic [N2_W-1:0]                    asq_in,
	input  wire logic [N2_W-1:0]                    n2_in,
	output logic signed [lbb_pkg::ROW_W-1:0]        row
);

	localparam int NS = lbb_pkg::ITER_STAGES;
	localparam int FW = lbb_pkg::F_W;
	localparam int RW = N2_W + 34;
	localparam int PW = N2_W + FW;

	// Remainder a^2*2^30 - f^2*n2, running product f*n2 and quotient f.
	logic [RW-1:0]   rem_s  [NS-1];
	logic [PW-1:0]   prod_s [NS-1];
	logic [N2_W-1:0] n2_s   [NS-1];
	logic [FW-1:0]   f_s    [NS];
	logic            neg_s  [NS];

	for (genvar j = 0; j < NS; j++) begin : g_step
		localparam int K = NS - 1 - j;

		logic [RW-1:0]   r_in;
		logic [PW-1:0]   p_in;
		logic [N2_W-1:0] n_in;
		logic [FW-1:0]   f_in;
		logic            s_in;
		logic [RW-1:0]   t;
		logic            take;

		if (j == 0) begin : g_first
			assign r_in = RW'(asq_in) << 30;
			assign p_in = '0;
			assign n_in = n2_in;
			assign f_in = '0;
			assign s_in = neg_in;
		end else begin : g_next
			assign r_in = rem_s[j-1];
			assign p_in = prod_s[j-1];
			assign n_in = n2_s[j-1];
			assign f_in = f_s[j-1];
			assign s_in = neg_s[j-1];
		end

		// Trial bit 2^K: (f + 2^K)^2 n2 - f^2 n2 = 2^(K+1) f n2 + 2^(2K) n2.
		assign t    = (RW'(p_in) << (K + 1)) + (RW'(n_in) << (2 * K));
		assign take = (r_in >= t);

		always_ff @(posedge clk) begin
			if (en[j]) begin
				f_s[j]   <= take ? (f_in | (FW'(1) << K)) : f_in;
				neg_s[j] <= s_in;
			end
		end

		if (j < NS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_s[j]  <= take ? (r_in - t) : r_in;
					prod_s[j] <= take ? (p_in + (PW'(n_in) << K)) : p_in;
					n2_s[j]   <= n_in;
				end
			end
		end
	end

	// The rounded quotient is the count of odd numbers up to floor(2 * ratio).
	logic [FW:0] q_mag;

	assign q_mag = ((FW + 1)'(f_s[NS-1]) + (FW + 1)'(1)) >> 1;
	assign row   = neg_s[NS-1] ? -signed'(lbb_pkg::ROW_W'(q_mag)) :
		signed'(lbb_pkg::ROW_W'(q_mag));

endmodule

`default_nettype wire

// ----- design/lbb_right.sv -----
//------------------------------------------------------------------------------
// lbb_right
// Right row as the cross product of the up and back rows, rounded to
// Q1.14, and the output register of the result transaction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbb_right (
	input  wire logic                                  clk,
	input  wire logic [lbb_pkg::BACK_STAGES-1:0]       en,
	input  wire logic [2:0][lbb_pkg::ROW_W-1:0]        up,
	input  wire logic [2:0][lbb_pkg::ROW_W-1:0]        bk,
	input  wire logic                                  degen,
	output logic [lbb_pkg::OUT_TDATA_W-1:0]            tdata,
	output logic                                       flag
);

	localparam int RWD = lbb_pkg::ROW_W;
	localparam int PWD = lbb_pkg::RP_W;

	// Stage 1: the six products of the cross product.
	logic signed [PWD-1:0] pa_s1 [3];
	logic signed [PWD-1:0] pb_s1 [3];
	logic [RWD-1:0]        up_s1 [3];
	logic [RWD-1:0]        bk_s1 [3];
	logic                  degen_s1;
	logic signed [PWD-1:0] ma [3];
	logic signed [PWD-1:0] mb [3];

	always_comb begin
		ma[0] = signed'(up[1]) * signed'(bk[2]);
		mb[0] = signed'(up[2]) * signed'(bk[1]);
		ma[1] = signed'(up[2]) * signed'(bk[0]);
		mb[1] = signed'(up[0]) * signed'(bk[2]);
		ma[2] = signed'(up[0]) * signed'(bk[1]);
		mb[2] = signed'(up[1]) * signed'(bk[0]);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < 3; k++) begin
				pa_s1[k] <= ma[k];
				pb_s1[k] <= mb[k];
				up_s1[k] <= up[k];
				bk_s1[k] <= bk[k];
			end
			degen_s1 <= degen;
		end
	end

	// Stage 2: difference, round half away from zero, saturate, clear on degenerate.
	logic signed [PWD:0] diff [3];
	logic [PWD:0]        dmag [3];
	logic [PWD:0]        qr [3];
	logic [RWD-1:0]      qs [3];
	logic [RWD-1:0]      rt [3];
	logic [RWD-1:0]      rt_s2 [3];
	logic [RWD-1:0]      up_s2 [3];
	logic [RWD-1:0]      bk_s2 [3];
	logic                degen_s2;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = (PWD + 1)'(pa_s1[k]) - (PWD + 1)'(pb_s1[k]);
			dmag[k] = diff[k][PWD] ? unsigned'(-diff[k]) : unsigned'(diff[k]);
			qr[k]   = (dmag[k] + (PWD + 1)'(lbb_pkg::Q_HALF)) >> lbb_pkg::Q_FRAC;
			qs[k]   = (qr[k] > (PWD + 1)'(lbb_pkg::Q_ONE)) ? RWD'(lbb_pkg::Q_ONE) :
				qr[k][RWD-1:0];
			rt[k]   = diff[k][PWD] ? (-qs[k]) : qs[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < 3; k++) begin
				rt_s2[k] <= degen_s1 ? '0 : rt[k];
				up_s2[k] <= degen_s1 ? '0 : up_s1[k];
				bk_s2[k] <= degen_s1 ? '0 : bk_s1[k];
			end
			degen_s2 <= degen_s1;
		end
	end

	assign tdata = {bk_s2[2], bk_s2[1], bk_s2[0], up_s2[2], up_s2[1], up_s2[0],
		rt_s2[2], rt_s2[1], rt_s2[0]};
	assign flag  = degen_s2;

endmodule

`default_nettype wire

// ----- design/look_at_basis_builder.sv -----
// Throughput: one transaction per cycle while the output drains or a stage is
// empty; the 16 quotient-bit stages of the normalization lanes set the depth,
// and the split 48-bit squaring sets the front.
// Empty stages keep filling while a finished result waits at the output.
// Reset clears only the stage valid bits; no result is pending after reset.
//------------------------------------------------------------------------------
// look_at_basis_builder
// Builds an orthonormal look-at basis (right, up, back rows in Q1.14) from
// a view direction and an approximate up vector.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module look_at_basis_builder #(
	parameter int COORD_BITS = lbb_pkg::COORD_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// dir_x, dir_y, dir_z, hint_x, hint_y, hint_z, COORD_BITS each, zero padded
	input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// right_x, right_y, right_z, upward_x, upward_y, upward_z, back_x, back_y, back_z
	output logic [lbb_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
	// degenerate
	output logic                                      m_axis_tuser
);

	localparam int FS = lbb_pkg::FRONT_STAGES;
	localparam int IS = lbb_pkg::ITER_STAGES;
	localparam int BS = lbb_pkg::BACK_STAGES;
	localparam int NS = lbb_pkg::NUM_STAGES;

	logic [NS-1:0] en;

	// Stage valid bits and load enables.
	lbb_pipe_ctrl #(
		.NUM_STAGES(NS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.en       (en)
	);

	logic [2:0][lbb_pkg::DSQ_W-1:0] dsq;
	logic [lbb_pkg::DSQ_W-1:0]      nd;
	logic [2:0]                     d_neg;
	logic [2:0][lbb_pkg::WSQ_W-1:0] wsq;
	logic [lbb_pkg::WSQ_W-1:0]      nw;
	logic [2:0]                     w_neg;
	logic                           degen;

	// Fit, cross products and squared lengths.
	lbb_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk   (clk),
		.en    (en[FS-1:0]),
		.coords(s_axis_tdata[6*COORD_BITS-1:0]),
		.dsq   (dsq),
		.nd    (nd),
		.d_neg (d_neg),
		.wsq   (wsq),
		.nw    (nw),
		.w_neg (w_neg),
		.degen (degen)
	);

	logic [2:0][lbb_pkg::ROW_W-1:0] bk_row;
	logic [2:0][lbb_pkg::ROW_W-1:0] up_row;

	// Six normalization lanes, three for back and three for up.
	for (genvar k = 0; k < 3; k++) begin : g_lane
		lbb_norm_lane #(
			.N2_W(lbb_pkg::DSQ_W)
		) u_back (
			.clk   (clk),
			.en    (en[FS +: IS]),
			.neg_in(d_neg[k]),
			.asq_in(dsq[k]),
			.n2_in (nd),
			.row   (bk_row[k])
		);

		lbb_norm_lane #(
			.N2_W(lbb_pkg::WSQ_W)
		) u_up (
			.clk   (clk),
			.en    (en[FS +: IS]),
			.neg_in(w_neg[k]),
			.asq_in(wsq[k]),
			.n2_in (nw),
			.row   (up_row[k])
		);
	end

	// Degenerate flag travels beside the lanes.
	logic degen_dly_q [IS];

	always_ff @(posedge clk) begin
		for (int j = 0; j < IS; j++) begin
			if (en[FS + j]) begin
				degen_dly_q[j] <= (j == 0) ? degen : degen_dly_q[(j == 0) ? 0 : j - 1];
			end
		end
	end

	// Right row and output register.
	lbb_right u_right (
		.clk  (clk),
		.en   (en[FS + IS +: BS]),
		.up   (up_row),
		.bk   (bk_row),
		.degen(degen_dly_q[IS-1]),
		.tdata(m_axis_tdata),
		.flag (m_axis_tuser)
	);

endmodule

`default_nettype wire

// ----- design/lbb_checker.sv -----
//------------------------------------------------------------------------------
// lbb_checker
// Port-level checks of the look-at basis builder, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbb_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tready,
	input  wire logic                                 m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	input  wire logic [lbb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	input  wire logic                                 m_axis_tuser
);

	// A stalled result transaction stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result transaction dropped while stalled");

	// A stalled result transaction keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result payload changed while stalled");

	// A degenerate basis carries all-zero rows.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("degenerate result with nonzero rows");

	// A draining output lets the pipeline take input.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");

	// An empty output stage never blocks input.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with free output stage");

endmodule

bind look_at_basis_builder lbb_checker u_lbb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
